// ----- rtl/tspg_pkg.sv -----
// Shared types, constants and fixed-point helpers for the triangle subdivision
// point generator. No dependencies; every other file of the block imports it.
package tspg_pkg;

   // Counter and number format.
   localparam int INDEX_BITS  = 32;
   localparam int FRAC_BITS   = 20;
   localparam int DIGITS      = (INDEX_BITS + 1) / 2;
   localparam int DIGIT_CNT_W = $clog2(DIGITS);
   localparam int ACC_W       = FRAC_BITS + 4;
   localparam int PROD_W      = 2 * ACC_W;
   localparam int SUM_W       = PROD_W + 2;

   // Port widths.
   localparam int OUT_W      = 24;
   localparam int R2_W       = 20;
   localparam int MODE_W     = 2;
   localparam int START_W    = 32;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 32;

   // Depth of the command queue between the front and the back.
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   // Point modes.
   localparam logic [MODE_W-1:0] MODE_TRIANGLE    = 2'd0;
   localparam logic [MODE_W-1:0] MODE_DISC        = 2'd1;
   localparam logic [MODE_W-1:0] MODE_SQUARE_SYM  = 2'd2;
   localparam logic [MODE_W-1:0] MODE_SQUARE_UNIT = 2'd3;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_POINT_MODE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_START_INDEX = 2'd1;

   // Constants held with 32 fraction bits.
   localparam logic [63:0] Q32_C    = 64'h0000_0000_DDB3_D743;
   localparam logic [63:0] Q32_SIZ  = 64'h0000_0000_BB67_AE86;
   localparam logic [63:0] Q32_SINV = 64'h0000_0001_5DB3_D743;

   // Round a 32-fraction-bit constant to FRAC_BITS fraction bits, ties up.
   function automatic logic [63:0] q32_to_fx(input logic [63:0] c);
      return (c + (64'd1 << (31 - FRAC_BITS))) >> (32 - FRAC_BITS);
   endfunction

   localparam logic signed [ACC_W-1:0] C_FX    = signed'(ACC_W'(q32_to_fx(Q32_C)));
   localparam logic signed [ACC_W-1:0] SIZ_FX  = signed'(ACC_W'(q32_to_fx(Q32_SIZ)));
   localparam logic [ACC_W-1:0]        SINV_FX = ACC_W'(q32_to_fx(Q32_SINV));
   localparam logic signed [ACC_W-1:0] ONE_FX  = signed'(ACC_W'(1) << FRAC_BITS);
   localparam logic signed [ACC_W-1:0] HALF_FX = signed'(ACC_W'(1) << (FRAC_BITS - 1));

   // Output saturation bounds.
   localparam logic signed [SUM_W-1:0] OUT_MAX_S = SUM_W'((1 << (OUT_W - 1)) - 1);
   localparam logic signed [SUM_W-1:0] OUT_MIN_S = -OUT_MAX_S - SUM_W'(1);

   // Configuration registers as seen by the back part.
   typedef struct packed {
      logic [MODE_W-1:0]  point_mode;
      logic [START_W-1:0] start_index;
   } cfg_type;

   // One queued command.
   typedef struct packed {
      logic restart;
   } cmd_type;

   // The C direction term scaled by 2^-k, rounded to nearest with ties up.
   function automatic logic signed [ACC_W-1:0] c_term(input logic [DIGIT_CNT_W-1:0] k);
      logic [ACC_W:0] t;
      t = {1'b0, C_FX};
      if (k != '0) begin
         t = (t + ((ACC_W + 1)'(1) << (k - 1'b1))) >> k;
      end
      return signed'(t[ACC_W-1:0]);
   endfunction

   // Saturate a signed value to the output coordinate width.
   function automatic logic [OUT_W-1:0] sat_out(input logic signed [SUM_W-1:0] v);
      logic signed [SUM_W-1:0] s;
      s = v;
      if (v > OUT_MAX_S) begin
         s = OUT_MAX_S;
      end else if (v < OUT_MIN_S) begin
         s = OUT_MIN_S;
      end
      return s[OUT_W-1:0];
   endfunction

endpackage

// ----- rtl/tspg_front.sv -----
// Front part: configuration registers, request acceptance and the command queue.
// Depends on tspg_pkg.
module tspg_front (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic                          req_restart,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [tspg_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tspg_pkg::CSR_DATA_W-1:0] csr_wdata,
   output tspg_pkg::cfg_type             cfg,
   output logic                          cmd_valid,
   output tspg_pkg::cmd_type             cmd,
   input  logic                          cmd_pop
);
   import tspg_pkg::*;

   cfg_type             cfg_ff, cfg_in;
   cmd_type             queue_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                push;

   // Register writes are always taken at once.
   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_POINT_MODE:  cfg_in.point_mode  = csr_wdata[MODE_W-1:0];
            CSR_START_INDEX: cfg_in.start_index = csr_wdata[START_W-1:0];
            default:         cfg_in = cfg_ff;
         endcase
      end
   end

   // Queue bookkeeping.
   assign req_ready = (count_ff != QCNT_W'(QUEUE_DEPTH));
   assign push      = req_valid && req_ready;
   assign cmd_valid = (count_ff != '0);
   assign cmd       = queue_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (cmd_pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !cmd_pop) begin
         count_in = count_ff + 1'b1;
      end else if (cmd_pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff    <= '0;
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         cfg_ff    <= cfg_in;
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // Queue storage.
   always_ff @(posedge clock) begin
      if (push) begin
         queue_ff[wr_ptr_ff].restart <= req_restart;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ----- rtl/tspg_back.sv -----
// Back part: sample counter, digit-serial triangle walk, acceptance test,
// square scaling and the result register. Depends on tspg_pkg.
module tspg_back (
   input  logic                         clock,
   input  logic                         reset,
   input  tspg_pkg::cfg_type            cfg,
   input  logic                         cmd_valid,
   input  tspg_pkg::cmd_type            cmd,
   output logic                         cmd_pop,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic signed [tspg_pkg::OUT_W-1:0] rsp_point_x,
   output logic signed [tspg_pkg::OUT_W-1:0] rsp_point_y,
   output logic [tspg_pkg::R2_W-1:0]    rsp_radius_squared
);
   import tspg_pkg::*;

   localparam int STATE_W = 3;
   localparam logic [STATE_W-1:0] ST_IDLE   = 3'd0;
   localparam logic [STATE_W-1:0] ST_GEN    = 3'd1;
   localparam logic [STATE_W-1:0] ST_CHECK  = 3'd2;
   localparam logic [STATE_W-1:0] ST_MUL_X  = 3'd3;
   localparam logic [STATE_W-1:0] ST_MUL_Y  = 3'd4;
   localparam logic [STATE_W-1:0] ST_FINISH = 3'd5;
   localparam logic [STATE_W-1:0] ST_OUT    = 3'd6;

   localparam logic [1:0] DIR_CENTRE      = 2'd0;
   localparam logic [1:0] DIR_UP          = 2'd1;
   localparam logic [1:0] DIR_LOWER_RIGHT = 2'd2;
   localparam logic [1:0] DIR_LOWER_LEFT  = 2'd3;

   localparam logic [PROD_W:0] DISC_LIMIT = (PROD_W + 1)'(1) << (2 * FRAC_BITS);
   localparam logic [PROD_W:0] R2_MAX     = (PROD_W + 1)'((1 << R2_W) - 1);

   // Round a magnitude product back to the coordinate scale and restore the sign.
   function automatic logic signed [SUM_W-1:0] scale_coord(
      input logic [PROD_W-1:0] prod,
      input logic              neg,
      input logic              unit
   );
      logic [PROD_W:0] p;
      logic signed [SUM_W-1:0] v;
      if (unit) begin
         p = ({1'b0, prod} + ((PROD_W + 1)'(1) << FRAC_BITS)) >> (FRAC_BITS + 1);
      end else begin
         p = ({1'b0, prod} + ((PROD_W + 1)'(1) << (FRAC_BITS - 1))) >> FRAC_BITS;
      end
      v = signed'(SUM_W'(p));
      if (neg) begin
         v = -v;
      end
      if (unit) begin
         v = v + SUM_W'(HALF_FX);
      end
      return v;
   endfunction

   logic [STATE_W-1:0]      state_ff, state_in;
   logic [INDEX_BITS-1:0]   cnt_ff, cnt_in;
   logic [INDEX_BITS-1:0]   shift_ff, shift_in;
   logic [DIGIT_CNT_W-1:0]  k_ff, k_in;
   logic signed [ACC_W-1:0] x_ff, x_in;
   logic signed [ACC_W-1:0] y_ff, y_in;
   logic                    neg_ff, neg_in;
   logic [PROD_W-1:0]       prod_x_ff, prod_x_in;
   logic [PROD_W-1:0]       prod_y_ff, prod_y_in;
   logic [OUT_W-1:0]        res_x_ff, res_x_in;
   logic [OUT_W-1:0]        res_y_ff, res_y_in;
   logic [R2_W-1:0]         res_r2_ff, res_r2_in;
   logic                    rsp_valid_ff, rsp_valid_in;
   logic [OUT_W-1:0]        rsp_x_ff, rsp_x_in;
   logic [OUT_W-1:0]        rsp_y_ff, rsp_y_in;
   logic [R2_W-1:0]         rsp_r2_ff, rsp_r2_in;

   logic signed [ACC_W-1:0] tx, ty;
   logic [ACC_W-1:0]        mag_x, mag_y, mul_a, mul_b;
   logic [PROD_W-1:0]       product;
   logic [PROD_W:0]         sum_sq, r2_full;
   logic                    in_square, out_free, unit_mode;
   logic signed [SUM_W-1:0] scaled_x, scaled_y;
   logic [INDEX_BITS-1:0]   first_n;

   // Direction term for the current digit.
   always_comb begin
      tx = '0;
      ty = '0;
      case (shift_ff[1:0])
         DIR_CENTRE: begin
            tx = '0;
            ty = '0;
         end
         DIR_UP: begin
            ty = ONE_FX >>> k_ff;
         end
         DIR_LOWER_RIGHT: begin
            tx = c_term(k_ff);
            ty = -(HALF_FX >>> k_ff);
         end
         DIR_LOWER_LEFT: begin
            tx = -c_term(k_ff);
            ty = -(HALF_FX >>> k_ff);
         end
         default: begin
            tx = '0;
            ty = '0;
         end
      endcase
   end

   // Shared multiplier: squares in disc mode, scale factor in the square modes.
   assign mag_x   = x_ff[ACC_W-1] ? ACC_W'(-x_ff) : ACC_W'(x_ff);
   assign mag_y   = y_ff[ACC_W-1] ? ACC_W'(-y_ff) : ACC_W'(y_ff);
   assign mul_a   = (state_ff == ST_MUL_X) ? mag_x : mag_y;
   assign mul_b   = (cfg.point_mode == MODE_DISC) ? mul_a : SINV_FX;
   assign product = PROD_W'(mul_a) * PROD_W'(mul_b);

   // Acceptance tests and final scaling.
   assign sum_sq    = {1'b0, prod_x_ff} + {1'b0, prod_y_ff};
   assign r2_full   = sum_sq >> FRAC_BITS;
   assign in_square = (x_ff >= -SIZ_FX) && (x_ff <= SIZ_FX) &&
                      (y_ff >= -SIZ_FX) && (y_ff <= SIZ_FX);
   assign unit_mode = (cfg.point_mode == MODE_SQUARE_UNIT);
   assign scaled_x  = scale_coord(prod_x_ff, x_ff[ACC_W-1], unit_mode);
   assign scaled_y  = scale_coord(prod_y_ff, y_ff[ACC_W-1], unit_mode);

   assign out_free = !rsp_valid_ff || rsp_ready;
   assign first_n  = cmd.restart ? cfg.start_index[INDEX_BITS-1:0] : cnt_ff;
   assign cmd_pop  = (state_ff == ST_IDLE) && cmd_valid;

   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      shift_in     = shift_ff;
      k_in         = k_ff;
      x_in         = x_ff;
      y_in         = y_ff;
      neg_in       = neg_ff;
      prod_x_in    = prod_x_ff;
      prod_y_in    = prod_y_ff;
      res_x_in     = res_x_ff;
      res_y_in     = res_y_ff;
      res_r2_in    = res_r2_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_x_in     = rsp_x_ff;
      rsp_y_in     = rsp_y_ff;
      rsp_r2_in    = rsp_r2_ff;

      case (state_ff)
         // Take a command and start the first candidate.
         ST_IDLE: begin
            if (cmd_valid) begin
               shift_in = first_n;
               cnt_in   = first_n + 1'b1;
               x_in     = '0;
               y_in     = '0;
               neg_in   = 1'b0;
               k_in     = '0;
               state_in = ST_GEN;
            end
         end
         // One base-4 digit per cycle, lowest first.
         ST_GEN: begin
            x_in     = neg_ff ? x_ff - tx : x_ff + tx;
            y_in     = neg_ff ? y_ff - ty : y_ff + ty;
            neg_in   = (shift_ff[1:0] == DIR_CENTRE) ? !neg_ff : neg_ff;
            shift_in = shift_ff >> 2;
            k_in     = k_ff + 1'b1;
            if (k_ff == DIGIT_CNT_W'(DIGITS - 1)) begin
               state_in = ST_CHECK;
            end
         end
         // Triangle mode is done; the square modes test the bounds here.
         ST_CHECK: begin
            res_r2_in = '0;
            if (cfg.point_mode == MODE_TRIANGLE) begin
               res_x_in = sat_out(SUM_W'(x_ff));
               res_y_in = sat_out(SUM_W'(y_ff));
               state_in = ST_OUT;
            end else if (cfg.point_mode == MODE_DISC || in_square) begin
               state_in = ST_MUL_X;
            end else begin
               shift_in = cnt_ff;
               cnt_in   = cnt_ff + 1'b1;
               x_in     = '0;
               y_in     = '0;
               neg_in   = 1'b0;
               k_in     = '0;
               state_in = ST_GEN;
            end
         end
         ST_MUL_X: begin
            prod_x_in = product;
            state_in  = ST_MUL_Y;
         end
         ST_MUL_Y: begin
            prod_y_in = product;
            state_in  = ST_FINISH;
         end
         // Disc test or square scaling.
         ST_FINISH: begin
            if (cfg.point_mode == MODE_DISC) begin
               if (sum_sq < DISC_LIMIT) begin
                  res_x_in  = sat_out(SUM_W'(x_ff));
                  res_y_in  = sat_out(SUM_W'(y_ff));
                  res_r2_in = (r2_full > R2_MAX) ? R2_MAX[R2_W-1:0] : r2_full[R2_W-1:0];
                  state_in  = ST_OUT;
               end else begin
                  shift_in = cnt_ff;
                  cnt_in   = cnt_ff + 1'b1;
                  x_in     = '0;
                  y_in     = '0;
                  neg_in   = 1'b0;
                  k_in     = '0;
                  state_in = ST_GEN;
               end
            end else begin
               res_x_in  = sat_out(scaled_x);
               res_y_in  = sat_out(scaled_y);
               res_r2_in = '0;
               state_in  = ST_OUT;
            end
         end
         // Hand the result to the output register once it is free.
         ST_OUT: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_x_in     = res_x_ff;
               rsp_y_in     = res_y_ff;
               rsp_r2_in    = res_r2_ff;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      shift_ff  <= shift_in;
      k_ff      <= k_in;
      x_ff      <= x_in;
      y_ff      <= y_in;
      neg_ff    <= neg_in;
      prod_x_ff <= prod_x_in;
      prod_y_ff <= prod_y_in;
      res_x_ff  <= res_x_in;
      res_y_ff  <= res_y_in;
      res_r2_ff <= res_r2_in;
      rsp_x_ff  <= rsp_x_in;
      rsp_y_ff  <= rsp_y_in;
      rsp_r2_ff <= rsp_r2_in;
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_point_x        = signed'(rsp_x_ff);
   assign rsp_point_y        = signed'(rsp_y_ff);
   assign rsp_radius_squared = rsp_r2_ff;

endmodule

// ----- rtl/triangle_subdivision_point_generator_core.sv -----
// Top level of the triangle subdivision point generator.
// Depends on tspg_pkg, tspg_front and tspg_back.
//
// Usage:
// Each request transaction on req_ carries one restart bit and yields exactly
// one response transaction on rsp_ with a point (x, y, signed, 20 fraction
// bits) and, in disc mode, its squared radius. With restart set, the sample
// counter is first reloaded from start_index. Registers are written on the
// csr_ channel (index 0 point_mode, index 1 start_index; other indexes are
// ignored), and the user must write them only while no transaction is in
// flight; the block itself does not enforce this. Requests go into a
// two-entry queue; the back part takes one at a time. A candidate point is
// walked one base-4 digit of the counter at a time (16 digits) by the
// digit-serial walk; each rejected candidate starts a new walk from the next
// counter value. Reset clears the registers, the counter and the queue; the
// block is ready in the cycle after reset is released. When the receiver
// stalls, the result waits in the output register, the next result waits in
// the back part's result register, and further requests fill the queue.
module triangle_subdivision_point_generator_core (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_restart,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic signed [tspg_pkg::OUT_W-1:0] rsp_point_x,
   output logic signed [tspg_pkg::OUT_W-1:0] rsp_point_y,
   output logic [tspg_pkg::R2_W-1:0]         rsp_radius_squared,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [tspg_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [tspg_pkg::CSR_DATA_W-1:0]   csr_wdata
);
   import tspg_pkg::*;

   cfg_type cfg;
   cmd_type cmd;
   logic    cmd_valid;
   logic    cmd_pop;

   // Front: registers and request queue.
   tspg_front u_front (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_restart (req_restart),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cfg         (cfg),
      .cmd_valid   (cmd_valid),
      .cmd         (cmd),
      .cmd_pop     (cmd_pop)
   );

   // Back: point generation and result register.
   tspg_back u_back (
      .clock              (clock),
      .reset              (reset),
      .cfg                (cfg),
      .cmd_valid          (cmd_valid),
      .cmd                (cmd),
      .cmd_pop            (cmd_pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_point_x        (rsp_point_x),
      .rsp_point_y        (rsp_point_y),
      .rsp_radius_squared (rsp_radius_squared)
   );

   // The squared radius is only reported in disc mode.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (cfg.point_mode != MODE_DISC)) |-> (rsp_radius_squared == '0))
      else $error("radius reported outside disc mode");

   // The queue only fills up as a result of an accepted request.
   assert property (@(posedge clock) disable iff (reset)
      $fell(req_ready) |-> $past(req_valid))
      else $error("request queue filled without a transaction");

   // The back part never takes a command from an empty queue.
   assert property (@(posedge clock) disable iff (reset)
      cmd_pop |-> cmd_valid)
      else $error("command taken from an empty queue");

endmodule
